[rtl/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/chaikin_pkg.sv]
package chaikin_pkg;

	localparam int COORD_W = 16;
	localparam int CNT_W   = 11;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// One classified request: both quarter points and the point itself.
	typedef struct packed {
		coord_t qx;
		coord_t qy;
		coord_t rx;
		coord_t ry;
		coord_t cx;
		coord_t cy;
		logic   first;
		logic   last;
	} work_t;

	typedef struct packed {
		logic emit;
		logic load_eop;
		cnt_t count;
	} back_stat_t;

endpackage

[rtl/chaikin_front.sv]
module chaikin_front import chaikin_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t point_x,
	input  coord_t point_y,
	input  logic   last_point,
	output logic   push_valid,
	input  logic   push_ready,
	output work_t  push_item
);

	coord_t prev_x_q;
	coord_t prev_y_q;
	logic   have_prev_q;
	logic   accept;

	// (3a + b) / 4, truncated toward zero.
	function automatic coord_t quarter(input coord_t a, input coord_t b);
		logic signed [COORD_W+2:0] a3;
		logic signed [COORD_W+2:0] s;
		a3 = (COORD_W+3)'(a) + ((COORD_W+3)'(a) <<< 1);
		s  = a3 + (COORD_W+3)'(b);
		if (s < 0) begin
			s = s + (COORD_W+3)'(3);
		end
		return s[COORD_W+1:2];
	endfunction

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	always_comb begin
		push_item.qx    = quarter(prev_x_q, point_x);
		push_item.qy    = quarter(prev_y_q, point_y);
		push_item.rx    = quarter(point_x, prev_x_q);
		push_item.ry    = quarter(point_y, prev_y_q);
		push_item.cx    = point_x;
		push_item.cy    = point_y;
		push_item.first = !have_prev_q;
		push_item.last  = last_point;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (accept) begin
			have_prev_q <= !last_point;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= point_x;
			prev_y_q <= point_y;
		end
	end

endmodule

[rtl/chaikin_queue.sv]
module chaikin_queue import chaikin_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_item
);

	localparam int Depth = 2;
	localparam int PtrW  = $clog2(Depth);

	work_t             mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [PtrW:0]     fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != (PtrW+1)'(Depth));
	assign pop_valid  = (fill_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[rtl/chaikin_back.sv]
module chaikin_back import chaikin_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  work_t      pop_item,
	input  cnt_t       cap,
	output logic       out_valid,
	input  logic       out_ready,
	output coord_t     out_x,
	output coord_t     out_y,
	output logic       point_valid,
	output logic       end_of_path,
	output back_stat_t stat
);

	localparam logic [1:0] STEP_Q   = 2'd0;
	localparam logic [1:0] STEP_R   = 2'd1;
	localparam logic [1:0] STEP_END = 2'd2;

	logic [1:0] step_q;
	logic       qr_en_q;
	cnt_t       count_q;
	coord_t     last_x_q;
	coord_t     last_y_q;
	logic       out_valid_q;
	coord_t     out_x_q;
	coord_t     out_y_q;
	logic       pvalid_q;
	logic       eop_q;

	coord_t cand_x;
	coord_t cand_y;
	logic   active;
	logic   is_end;
	logic   final_step;
	logic   qr_ok;
	logic   dup;
	logic   capped;
	logic   emit;
	logic   need_out;
	logic   advance;

	// Quarter points are only produced while two more points fit under the cap.
	assign qr_ok = (({1'b0, count_q} + (CNT_W+1)'(2)) < {1'b0, cap});

	always_comb begin
		cand_x     = pop_item.cx;
		cand_y     = pop_item.cy;
		active     = 1'b0;
		is_end     = 1'b0;
		final_step = 1'b1;
		unique case (step_q)
			STEP_Q: begin
				if (pop_item.first) begin
					active = 1'b1;
				end else begin
					cand_x = pop_item.qx;
					cand_y = pop_item.qy;
					active = qr_ok;
				end
				final_step = pop_item.first && !pop_item.last;
			end
			STEP_R: begin
				cand_x     = pop_item.rx;
				cand_y     = pop_item.ry;
				active     = qr_en_q;
				final_step = !pop_item.last;
			end
			STEP_END: begin
				active = 1'b1;
				is_end = 1'b1;
			end
			default: begin
				active = 1'b0;
			end
		endcase
	end

	assign dup      = (count_q != '0) && (last_x_q == cand_x) && (last_y_q == cand_y);
	assign capped   = (count_q >= cap);
	assign emit     = active && !dup && !capped;
	assign need_out = emit || is_end;
	assign advance  = pop_valid && (!need_out || !out_valid_q || out_ready);
	assign pop_ready = advance && final_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_Q;
			qr_en_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (need_out) begin
					out_valid_q <= 1'b1;
				end
				if (final_step) begin
					step_q <= STEP_Q;
				end else begin
					step_q <= step_q + 2'd1;
				end
				if (step_q == STEP_Q) begin
					qr_en_q <= !pop_item.first && qr_ok;
				end
				if (is_end) begin
					count_q <= '0;
				end else if (emit) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			last_x_q <= cand_x;
			last_y_q <= cand_y;
		end
		if (advance && need_out) begin
			// A dropped endpoint leaves a bare end marker at the origin.
			out_x_q  <= emit ? cand_x : '0;
			out_y_q  <= emit ? cand_y : '0;
			pvalid_q <= emit;
			eop_q    <= is_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign point_valid = pvalid_q;
	assign end_of_path = eop_q;

	assign stat.emit     = advance && emit;
	assign stat.load_eop = advance && is_end;
	assign stat.count    = count_q;

endmodule

[rtl/chaikin_path_smoothing_pass.sv]
// A result passes through the queue entry and the back output register before it is offered.
// Throughput: at most one result per cycle while out_ready stays high; the back sequencer runs
// step Q for a first point that does not end its path, steps Q and R for an inner point and Q, R
// and END for a last point, and pops a request only after its final step. A two-entry queue
// between front and back lets input requests keep coming while results wait. Reset clears all
// control state and loads the cap register with min(MAX_POINTS, 2047); there is no clearing pass.
`include "assert_macros.svh"

module chaikin_path_smoothing_pass import chaikin_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t point_x,
	input  coord_t point_y,
	input  logic   last_point,
	output logic   out_valid,
	input  logic   out_ready,
	output coord_t out_x,
	output coord_t out_y,
	output logic   point_valid,
	output logic   end_of_path,
	input  logic   cfg_valid,
	output logic   cfg_ready,
	input  cnt_t   max_points
);

	localparam int   CntMax   = (1 << CNT_W) - 1;
	localparam cnt_t CapReset = (MAX_POINTS > CntMax) ? cnt_t'(CntMax) : cnt_t'(MAX_POINTS);

	cnt_t       max_points_q;
	cnt_t       cap;
	logic       push_valid;
	logic       push_ready;
	work_t      push_item;
	logic       pop_valid;
	logic       pop_ready;
	work_t      pop_item;
	back_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_points_q <= CapReset;
		end else if (cfg_valid) begin
			max_points_q <= max_points;
		end
	end

	// The cap in force is the smaller of the register and the build-time limit.
	assign cap = (int'(max_points_q) < MAX_POINTS) ? max_points_q : CapReset;

	chaikin_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	chaikin_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	chaikin_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.cap         (cap),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.point_valid (point_valid),
		.end_of_path (end_of_path),
		.stat        (stat)
	);

	`CHK_SAME(a_marker_form, out_valid && !point_valid, end_of_path && out_x == '0 && out_y == '0, "bare marker malformed")
	`CHK_SAME(a_emit_under_cap, stat.emit, stat.count < cap, "point emitted at or above cap")
	`CHK_NEXT(a_count_cleared, stat.load_eop, stat.count == '0, "count not cleared after path end")

endmodule

[tb/chaikin_path_smoothing_pass_tb.sv]
`timescale 1ns / 100ps

module chaikin_path_smoothing_pass_tb;
	import chaikin_pkg::*;

	localparam int MAX_PTS = 1024;
	localparam int RAND_ITEMS = 260;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   pv;
		logic   eop;
	} path_pt_t;

	localparam path_pt_t END_MARK = {16'sd0, 16'sd0, 1'b0, 1'b1};

	typedef enum logic {ROW_POINT, ROW_CAP} row_kind_t;
	typedef enum int {ST_WIDE, ST_NEAR, ST_EDGE, ST_HOLD} coord_style_t;

	typedef struct {
		row_kind_t kind;
		cnt_t cap;
		coord_t x;
		coord_t y;
		logic last;
		int n_known;
		path_pt_t [1:0] known;
	} stim_row_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	coord_t point_x;
	coord_t point_y;
	logic   last_point;
	logic   out_valid;
	logic   out_ready;
	coord_t out_x;
	coord_t out_y;
	logic   point_valid;
	logic   end_of_path;
	logic   cfg_valid;
	logic   cfg_ready;
	cnt_t   max_points;

	// Expectation typed in for the request currently offered; -1 means use the predictor.
	int typed_n;
	path_pt_t [1:0] typed_pts;

	path_pt_t want_pts[$];
	int mismatch_cnt = 0;
	bit idle_on = 1'b1;

	// Predictor state.
	int cap_reg = MAX_PTS;
	int sm_prev_x = 0;
	int sm_prev_y = 0;
	bit sm_have_prev = 1'b0;
	int sm_count = 0;
	int sm_last_x = 0;
	int sm_last_y = 0;

	stim_row_t dir_rows[$];

	chaikin_path_smoothing_pass #(
		.MAX_POINTS(MAX_PTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_x(point_x),
		.point_y(point_y),
		.last_point(last_point),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.point_valid(point_valid),
		.end_of_path(end_of_path),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_points(max_points)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(2_000_000);
		$display("FAIL chaikin_path_smoothing_pass");
		$finish;
	end

	function automatic path_pt_t pt(int x, int y, bit pv, bit eop);
		path_pt_t p;
		p.x = coord_t'(x);
		p.y = coord_t'(y);
		p.pv = pv;
		p.eop = eop;
		return p;
	endfunction

	function automatic stim_row_t row_known(int x, int y, bit last, int n,
			path_pt_t a, path_pt_t b);
		stim_row_t r;
		r.kind = ROW_POINT;
		r.cap = '0;
		r.x = coord_t'(x);
		r.y = coord_t'(y);
		r.last = last;
		r.n_known = n;
		r.known[0] = a;
		r.known[1] = b;
		return r;
	endfunction

	function automatic stim_row_t row_pt(int x, int y, bit last);
		return row_known(x, y, last, -1, '0, '0);
	endfunction

	function automatic stim_row_t row_cap(int v);
		stim_row_t r;
		r = row_known(0, 0, 1'b0, -1, '0, '0);
		r.kind = ROW_CAP;
		r.cap = cnt_t'(v);
		return r;
	endfunction

	function automatic int path_cap();
		return (cap_reg < MAX_PTS) ? cap_reg : MAX_PTS;
	endfunction

	function automatic bit take_point(int x, int y);
		if (sm_count > 0 && sm_last_x == x && sm_last_y == y)
			return 1'b0;
		if (sm_count >= path_cap())
			return 1'b0;
		sm_last_x = x;
		sm_last_y = y;
		sm_count++;
		return 1'b1;
	endfunction

	// One corner-cutting step for an accepted point; keep selects whether its
	// results become the expectation.
	function automatic void smooth_point(coord_t cx, coord_t cy, logic last, bit keep);
		path_pt_t made[$];
		int qx, qy, rx, ry;
		if (!sm_have_prev) begin
			if (take_point(cx, cy))
				made.push_back(pt(cx, cy, 1'b1, 1'b0));
		end else if (sm_count + 2 < path_cap()) begin
			qx = (sm_prev_x * 3 + cx) / 4;
			qy = (sm_prev_y * 3 + cy) / 4;
			rx = (sm_prev_x + cx * 3) / 4;
			ry = (sm_prev_y + cy * 3) / 4;
			if (take_point(qx, qy))
				made.push_back(pt(qx, qy, 1'b1, 1'b0));
			if (take_point(rx, ry))
				made.push_back(pt(rx, ry, 1'b1, 1'b0));
		end
		if (last) begin
			if (take_point(cx, cy))
				made.push_back(pt(cx, cy, 1'b1, 1'b1));
			else
				made.push_back(END_MARK);
			sm_have_prev = 1'b0;
			sm_count = 0;
			sm_prev_x = 0;
			sm_prev_y = 0;
		end else begin
			sm_prev_x = cx;
			sm_prev_y = cy;
			sm_have_prev = 1'b1;
		end
		if (keep)
			foreach (made[k])
				want_pts.push_back(made[k]);
	endfunction

	always @(posedge clk) begin
		path_pt_t exp_pt;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (want_pts.size() == 0) begin
					$display("%0t: result with none expected: x=%0d y=%0d pv=%0b eop=%0b",
						$time, out_x, out_y, point_valid, end_of_path);
					mismatch_cnt++;
				end else begin
					exp_pt = want_pts.pop_front();
					if (out_x !== exp_pt.x) begin
						$display("%0t: out_x expected %0d, got %0d", $time, exp_pt.x, out_x);
						mismatch_cnt++;
					end
					if (out_y !== exp_pt.y) begin
						$display("%0t: out_y expected %0d, got %0d", $time, exp_pt.y, out_y);
						mismatch_cnt++;
					end
					if (point_valid !== exp_pt.pv) begin
						$display("%0t: point_valid expected %0b, got %0b", $time, exp_pt.pv,
							point_valid);
						mismatch_cnt++;
					end
					if (end_of_path !== exp_pt.eop) begin
						$display("%0t: end_of_path expected %0b, got %0b", $time, exp_pt.eop,
							end_of_path);
						mismatch_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				cap_reg = max_points;
			if (in_valid && in_ready) begin
				smooth_point(point_x, point_y, last_point, typed_n < 0);
				for (int i = 0; i < typed_n; i++)
					want_pts.push_back(typed_pts[i]);
			end
		end
	end

	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_point(input coord_t x, input coord_t y, input logic last,
			input int n_known, input path_pt_t [1:0] known);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		last_point <= last;
		typed_n <= n_known;
		typed_pts <= known;
		do @(posedge clk); while (!in_ready);
	endtask

	// The cap is only changed once every result is out; an inner point can
	// produce nothing, so the task also lets the queue and back side settle before the write.
	task automatic write_cap(input int v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (want_pts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		max_points <= cnt_t'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic coord_t next_coord(coord_t prev, coord_style_t sty);
		int v;
		case (sty)
			ST_WIDE: return coord_t'($urandom);
			ST_NEAR: begin
				v = int'(prev) + int'($urandom_range(0, 6)) - 3;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				return coord_t'(v);
			end
			ST_EDGE: begin
				case ($urandom_range(0, 3))
					0: return coord_t'(-32768);
					1: return coord_t'(32767);
					2: return coord_t'(-1);
					default: return coord_t'(0);
				endcase
			end
			default: return prev;
		endcase
	endfunction

	initial begin
		int sent;
		int path_left;
		int phase_len;
		int cap_v;
		coord_style_t sty;
		coord_t rx, ry;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		last_point <= 1'b0;
		typed_n <= -1;
		typed_pts <= '0;
		cfg_valid <= 1'b0;
		max_points <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First point after reset, full-scale swings, and truncation of negative sums.
		dir_rows.push_back(row_known(0, 0, 1'b0, 1, pt(0, 0, 1'b1, 1'b0), '0));
		dir_rows.push_back(row_pt(32767, 32767, 1'b0));
		dir_rows.push_back(row_pt(-32768, -32768, 1'b0));
		dir_rows.push_back(row_pt(-32768, 32767, 1'b1));
		// A path of one point ends with a bare end marker.
		dir_rows.push_back(row_known(100, -100, 1'b1, 2, pt(100, -100, 1'b1, 1'b0), END_MARK));
		dir_rows.push_back(row_known(-3, 5, 1'b0, 1, pt(-3, 5, 1'b1, 1'b0), '0));
		dir_rows.push_back(row_pt(-6, 2, 1'b1));
		// Repeated points: every emission after the first is a duplicate.
		dir_rows.push_back(row_known(7, 7, 1'b0, 1, pt(7, 7, 1'b1, 1'b0), '0));
		dir_rows.push_back(row_known(7, 7, 1'b0, 0, '0, '0));
		dir_rows.push_back(row_known(7, 7, 1'b1, 1, END_MARK, '0));
		// With a zero cap only end markers come out.
		dir_rows.push_back(row_cap(0));
		dir_rows.push_back(row_known(5, 5, 1'b1, 1, END_MARK, '0));
		dir_rows.push_back(row_known(5, 5, 1'b0, 0, '0, '0));
		dir_rows.push_back(row_known(6, 6, 1'b1, 1, END_MARK, '0));
		dir_rows.push_back(row_cap(1));
		dir_rows.push_back(row_known(10, 10, 1'b0, 1, pt(10, 10, 1'b1, 1'b0), '0));
		dir_rows.push_back(row_known(20, 20, 1'b1, 1, END_MARK, '0));
		dir_rows.push_back(row_cap(3));
		dir_rows.push_back(row_pt(0, 0, 1'b0));
		dir_rows.push_back(row_pt(8, 8, 1'b0));
		dir_rows.push_back(row_pt(16, 16, 1'b1));
		dir_rows.push_back(row_cap(2047));
		dir_rows.push_back(row_pt(1, 2, 1'b0));
		dir_rows.push_back(row_pt(-1, -2, 1'b1));
		dir_rows.push_back(row_cap(1024));
		dir_rows.push_back(row_pt(1000, 1000, 1'b0));
		// Cap lowered in the middle of a path takes effect on the next point.
		dir_rows.push_back(row_cap(2));
		dir_rows.push_back(row_pt(2000, 2000, 1'b1));
		dir_rows.push_back(row_cap(1024));
		dir_rows.push_back(row_pt(-32768, -32768, 1'b0));
		dir_rows.push_back(row_pt(32767, -32768, 1'b1));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CAP)
				write_cap(dir_rows[i].cap);
			else
				send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
					dir_rows[i].n_known, dir_rows[i].known);
		end

		sent = 0;
		path_left = 0;
		sty = ST_WIDE;
		rx = '0;
		ry = '0;
		while (sent < RAND_ITEMS) begin
			idle_on = (sent < RAND_ITEMS - 40) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 5))
				0: cap_v = $urandom_range(0, 3);
				1, 2: cap_v = $urandom_range(4, 24);
				3: cap_v = 1024;
				4: cap_v = 2047;
				default: cap_v = $urandom_range(0, 2047);
			endcase
			write_cap(cap_v);
			phase_len = $urandom_range(4, 30);
			repeat (phase_len) begin
				if (sent >= RAND_ITEMS - 40)
					idle_on = 1'b0;
				if (path_left == 0) begin
					path_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
						: $urandom_range(3, 16);
					sty = coord_style_t'($urandom_range(0, 3));
					rx = coord_t'($urandom);
					ry = coord_t'($urandom);
				end
				rx = next_coord(rx, sty);
				ry = next_coord(ry, sty);
				path_left--;
				send_point(rx, ry, path_left == 0, -1, '0);
				sent++;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (want_pts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("PASS chaikin_path_smoothing_pass");
		else
			$display("FAIL chaikin_path_smoothing_pass");
		$finish;
	end

endmodule
